@@ design/spre_pkg.sv @@
package spre_pkg;

  localparam int unsigned NODE_IDX_W = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned WEIGHT_W   = 32;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [0:0] {
    CFG_NODE_COUNT  = 1'b0,
    CFG_SOURCE_NODE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [NODE_IDX_W-1:0]   edge_from;
    logic [NODE_IDX_W-1:0]   edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [NODE_IDX_W-1:0]   query_node;
  } spre_in_t;

endpackage

@@ design/spre_in_if.sv @@
interface spre_in_if;
  import spre_pkg::*;
  logic     valid;
  logic     ready;
  spre_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/spre_out_if.sv @@
interface spre_out_if #(parameter int DIST_WIDTH = 48);
  logic                         valid;
  logic                         ready;
  logic signed [DIST_WIDTH-1:0] distance;
  logic                         reachable;
  logic                         negative_cycle;
  logic                         edge_overflow;
  modport source (output valid, output distance, output reachable,
                  output negative_cycle, output edge_overflow, input ready);
  modport sink (input valid, input distance, input reachable,
                input negative_cycle, input edge_overflow, output ready);
endinterface

@@ design/shortest_path_relaxation_engine_unit.sv @@
// A load is stored when it is accepted; a query passes S_QREAD and S_QOUT before its result is valid.
// A run first clears the reach flags over all MAX_NODES entries in S_INIT, then makes
// passes <= node_count-1 (early exit on a pass without change) and a check pass that
// stops at the first relaxable edge; each edge visit uses the one edge-store port and
// one distance-memory read port in sequence, through S_EREAD, S_UREAD, S_VREAD, S_RELAX.
// After reset a clearing pass (S_CLEAR) writes all MAX_NODES reach flags; no item is taken.
module shortest_path_relaxation_engine_unit #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_EDGES  = 4096,
  parameter int DIST_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  spre_in_if.sink            in_ch,
  spre_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [spre_pkg::CNT_W-1:0] cfg_data
);
  import spre_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int SW = ((DIST_WIDTH > WEIGHT_W) ? DIST_WIDTH : WEIGHT_W) + 2;
  localparam logic [NW:0] CLR_LAST = (NW+1)'(MAX_NODES - 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_INIT  = 10'b0000000100,
    S_EREAD = 10'b0000001000,
    S_UREAD = 10'b0000010000,
    S_VREAD = 10'b0000100000,
    S_RELAX = 10'b0001000000,
    S_QREAD = 10'b0010000000,
    S_QOUT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CNT_W-1:0]      node_count_r;
  logic [NODE_IDX_W-1:0] source_node_r;
  logic [NCW-1:0]        n_eff;
  always_comb begin
    if (node_count_r == '0) n_eff = NCW'(1);
    else if (32'(node_count_r) > MAX_NODES) n_eff = NCW'(MAX_NODES);
    else n_eff = NCW'(node_count_r);
  end

  // memories
  logic [2*NODE_IDX_W+WEIGHT_W-1:0] edge_mem [MAX_EDGES];
  logic [DIST_WIDTH-1:0]            dist_mem [MAX_NODES];
  logic                             reach_mem [MAX_NODES];

  logic [ETW-1:0] edge_total_r;
  logic           cycle_r, overflow_r;
  logic [EW-1:0]  k_r;
  logic [NCW-1:0] pass_r;
  logic           changed_r, final_r;
  logic [NW:0]    clr_r;

  logic [NODE_IDX_W-1:0] eu_r, ev_r;
  logic signed [WEIGHT_W-1:0] ew_r;
  logic [DIST_WIDTH-1:0] rd_dist_r;
  logic                  rd_reach_r;
  logic signed [DIST_WIDTH-1:0] du_r;
  logic                  ru_r;

  logic signed [DIST_WIDTH-1:0] odist_r;
  logic ovalid_r, oreach_r;
  logic [NODE_IDX_W-1:0] q_r;

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  wire acc = in_ch.valid && in_ch.ready;
  wire [1:0] rt = in_ch.data.req_type;

  // relaxation arithmetic: exact sum and saturation
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (DIST_WIDTH-1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);
  logic signed [SW-1:0] sum;
  logic signed [DIST_WIDTH-1:0] sat;
  logic below, above, relax, edge_ok, last_edge;
  always_comb begin
    sum = SW'(du_r) + SW'(ew_r);
    below = sum < LO;
    above = sum > HI;
    sat = below ? LO[DIST_WIDTH-1:0] : above ? HI[DIST_WIDTH-1:0] : sum[DIST_WIDTH-1:0];
    edge_ok = (NCW'(eu_r) < n_eff) && (NCW'(ev_r) < n_eff);
    relax = edge_ok && ru_r &&
            (!rd_reach_r || (!above && (below || sum < SW'($signed(rd_dist_r)))));
    last_edge = (ETW'(k_r) + ETW'(1)) >= edge_total_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE: if (acc) begin
        priority case (rt)
          REQ_RUN:   state_nxt = S_INIT;
          REQ_QUERY: state_nxt = S_QREAD;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_INIT: begin
        if (clr_r == CLR_LAST)
          state_nxt = ((NCW'(source_node_r) >= n_eff) || edge_total_r == '0) ? S_OUT : S_EREAD;
      end
      S_EREAD: state_nxt = S_UREAD;
      S_UREAD: state_nxt = S_VREAD;
      S_VREAD: state_nxt = S_RELAX;
      S_RELAX: begin
        if (final_r && relax) state_nxt = S_OUT;
        else if (!last_edge) state_nxt = S_EREAD;
        else if (final_r) state_nxt = S_OUT;
        else state_nxt = S_EREAD;
      end
      S_QREAD: state_nxt = S_QOUT;
      S_QOUT:  state_nxt = S_IDLE;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory ports
  logic [NW-1:0] rd_addr;
  always_comb begin
    priority case (1'b1)
      state_r == S_UREAD:  rd_addr = NW'(eu_r);
      state_r == S_IDLE:   rd_addr = NW'(in_ch.data.query_node);
      state_r == S_QREAD:  rd_addr = NW'(q_r);
      default:             rd_addr = NW'(ev_r);
    endcase
  end
  always_ff @(posedge clk) begin
    if (acc && rt == REQ_LOAD && edge_total_r < ETW'(MAX_EDGES))
      edge_mem[edge_total_r[EW-1:0]] <= {in_ch.data.edge_from, in_ch.data.edge_to,
                                         in_ch.data.edge_weight};
    rd_dist_r  <= dist_mem[rd_addr];
    rd_reach_r <= reach_mem[rd_addr];
    if (state_r == S_CLEAR || state_r == S_INIT)
      reach_mem[clr_r[NW-1:0]] <= (state_r == S_INIT) &&
                                   (clr_r[NW-1:0] == NW'(source_node_r)) &&
                                   (NCW'(source_node_r) < n_eff);
    else if (state_r == S_RELAX && relax && !final_r)
      reach_mem[NW'(ev_r)] <= 1'b1;
    if (state_r == S_INIT && clr_r[NW-1:0] == NW'(source_node_r))
      dist_mem[NW'(source_node_r)] <= '0;
    else if (state_r == S_RELAX && relax && !final_r)
      dist_mem[NW'(ev_r)] <= sat;
  end

  // edge fetch: eu_r, ev_r and ew_r hold edge k_r from S_UREAD on
  always_ff @(posedge clk) begin
    if (state_r == S_EREAD)
      {eu_r, ev_r, ew_r} <= edge_mem[k_r];
    if (state_r == S_VREAD) begin
      du_r <= $signed(rd_dist_r);
      ru_r <= rd_reach_r;
    end
    if (acc) q_r <= in_ch.data.query_node;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      node_count_r <= CNT_W'(1);
      source_node_r <= '0;
      edge_total_r <= '0;
      cycle_r <= 1'b0;
      overflow_r <= 1'b0;
      clr_r <= '0;
      k_r <= '0;
      pass_r <= '0;
      changed_r <= 1'b0;
      final_r <= 1'b0;
      ovalid_r <= 1'b0;
      oreach_r <= 1'b0;
      odist_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_count_r <= cfg_data;
        else source_node_r <= cfg_data[NODE_IDX_W-1:0];
      end
      if (state_r == S_CLEAR || state_r == S_INIT) clr_r <= clr_r + 1'b1;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          if (rt == REQ_LOAD) begin
            if (edge_total_r < ETW'(MAX_EDGES)) edge_total_r <= edge_total_r + 1'b1;
            else overflow_r <= 1'b1;
          end
          if (rt == REQ_RUN) begin
            cycle_r <= 1'b0;
            clr_r <= '0;
            k_r <= '0;
            pass_r <= NCW'(1);
            changed_r <= 1'b0;
            final_r <= (n_eff == NCW'(1));
          end
        end
        S_RELAX: begin
          if (final_r && relax) cycle_r <= 1'b1;
          if (!last_edge) begin
            k_r <= k_r + 1'b1;
            if (relax) changed_r <= 1'b1;
          end else begin
            k_r <= '0;
            changed_r <= 1'b0;
            pass_r <= pass_r + 1'b1;
            // next pass is final after node_count-1 passes or a quiet pass
            if (!(changed_r || relax) || pass_r + NCW'(1) >= n_eff) final_r <= 1'b1;
          end
        end
        S_QOUT: begin
          ovalid_r <= 1'b1;
          oreach_r <= !cycle_r && (NCW'(q_r) < n_eff) && rd_reach_r;
          odist_r  <= (!cycle_r && (NCW'(q_r) < n_eff) && rd_reach_r) ?
                      $signed(rd_dist_r) : '0;
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          oreach_r <= 1'b0;
          odist_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.distance       = odist_r;
  assign out_ch.reachable      = oreach_r;
  assign out_ch.negative_cycle = cycle_r;
  assign out_ch.edge_overflow  = overflow_r;

`ifndef SYNTHESIS
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(odist_r))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready)
    else $error("ready while busy");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= ETW'(MAX_EDGES))
    else $error("edge count overrun");
`endif
endmodule

@@ tb/sv/spre_checker.sv @@
module spre_checker (
  input  logic        clk,
  input  logic        rst_n,
  spre_in_if          in_ch,
  spre_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          cycles_flagged
);
  import spre_pkg::*;

  localparam int      NODES = 1024;
  localparam int      EDGES = 4096;
  localparam longint  DIST_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint  DIST_LO = -DIST_HI - 1;

  typedef struct {
    logic signed [47:0] distance;
    bit                 reachable;
    bit                 negative_cycle;
    bit                 edge_overflow;
  } path_result_t;

  path_result_t expected_results[$];

  logic [10:0] node_count;
  logic [9:0]  source_node;
  logic [9:0]  edge_src [EDGES];
  logic [9:0]  edge_dst [EDGES];
  longint      edge_wt [EDGES];
  int          edge_total;
  longint      node_dist [NODES];
  bit          node_reached [NODES];
  bit          cycle_seen;
  bit          overflow_seen;

  assign pending = expected_results.size();

  // append one expectation at the tail of the queue
  function automatic void expect_result(path_result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic int active_nodes();
    if (node_count == 0) return 1;
    if (node_count > NODES) return NODES;
    return int'(node_count);
  endfunction

  // Decide whether edge k lowers its end node; give the saturated new distance
  function automatic bit relax_edge(int k, output longint nd);
    int     u;
    int     v;
    longint s;
    bit     below;
    u = int'(edge_src[k]);
    v = int'(edge_dst[k]);
    nd = 0;
    if (!node_reached[u]) return 0;
    s = node_dist[u] + edge_wt[k];
    below = (s < DIST_LO);
    nd = below ? DIST_LO : (s > DIST_HI ? DIST_HI : s);
    if (node_reached[v] && !below && !(s < node_dist[v])) return 0;
    return 1;
  endfunction

  task automatic run_shortest_paths();
    int     n;
    bit     changed;
    longint nd;
    n = active_nodes();
    for (int i = 0; i < NODES; i++) node_reached[i] = 0;
    cycle_seen = 0;
    if (source_node >= n) return;
    node_dist[source_node] = 0;
    node_reached[source_node] = 1;
    for (int r = 1; r < n; r++) begin
      changed = 0;
      for (int k = 0; k < edge_total; k++) begin
        if (edge_src[k] >= n || edge_dst[k] >= n) continue;
        if (relax_edge(k, nd)) begin
          node_dist[edge_dst[k]] = nd;
          node_reached[edge_dst[k]] = 1;
          changed = 1;
        end
      end
      if (!changed) break;
    end
    // one extra pass: anything still relaxable means a negative cycle
    for (int k = 0; k < edge_total; k++) begin
      if (edge_src[k] >= n || edge_dst[k] >= n) continue;
      if (relax_edge(k, nd)) begin
        cycle_seen = 1;
        break;
      end
    end
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)",
             field, got, want, results_seen);
    fail_count++;
  endtask

  always @(posedge clk) begin
    path_result_t res;
    path_result_t want;
    spre_in_t     item;
    if (!rst_n) begin
      node_count = 11'd1;
      source_node = '0;
      edge_total = 0;
      for (int i = 0; i < NODES; i++) node_reached[i] = 0;
      cycle_seen = 0;
      overflow_seen = 0;
      expected_results.delete();
      fail_count = 0;
      results_seen = 0;
      cycles_flagged = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_count = cfg_data;
        else source_node = cfg_data[9:0];
      end
      // predict each accepted item
      if (in_ch.valid && in_ch.ready) begin
        item = in_ch.data;
        case (item.req_type)
          REQ_LOAD: begin
            if (edge_total >= EDGES) begin
              overflow_seen = 1;
            end else begin
              edge_src[edge_total] = item.edge_from;
              edge_dst[edge_total] = item.edge_to;
              edge_wt[edge_total] = longint'(item.edge_weight);
              edge_total++;
            end
          end
          REQ_RUN: begin
            run_shortest_paths();
            if (cycle_seen) cycles_flagged++;
            res.distance = '0;
            res.reachable = 0;
            res.negative_cycle = cycle_seen;
            res.edge_overflow = overflow_seen;
            expect_result(res);
          end
          REQ_QUERY: begin
            res.distance = '0;
            res.reachable = 0;
            res.negative_cycle = cycle_seen;
            res.edge_overflow = overflow_seen;
            if (!cycle_seen && item.query_node < active_nodes() &&
                node_reached[item.query_node]) begin
              res.distance = node_dist[item.query_node][47:0];
              res.reachable = 1;
            end
            expect_result(res);
          end
          default: ;
        endcase
      end
      // compare each accepted result with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("unexpected result %0d with nothing pending", results_seen);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.distance !== want.distance)
            report("distance", longint'(out_ch.distance), longint'(want.distance));
          if (out_ch.reachable !== want.reachable)
            report("reachable", longint'(out_ch.reachable), longint'(want.reachable));
          if (out_ch.negative_cycle !== want.negative_cycle)
            report("negative_cycle", longint'(out_ch.negative_cycle),
                   longint'(want.negative_cycle));
          if (out_ch.edge_overflow !== want.edge_overflow)
            report("edge_overflow", longint'(out_ch.edge_overflow),
                   longint'(want.edge_overflow));
        end
      end
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import spre_pkg::*;

  localparam int CYCLE_LIMIT = 100000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_data;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          cycles_flagged;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          loads_sent;
  int          items_sent;

  spre_in_if                     in_ch ();
  spre_out_if #(.DIST_WIDTH(48)) out_ch ();

  shortest_path_relaxation_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spre_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .cycles_flagged (cycles_flagged)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // randomly stall the result side
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  // present one item and hold it until accepted
  task automatic send(req_type_t req, logic [9:0] from, logic [9:0] to,
                      logic [31:0] wt, logic [9:0] qn);
    spre_in_t item;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
    item.req_type = req;
    item.edge_from = from;
    item.edge_to = to;
    item.edge_weight = wt;
    item.query_node = qn;
    in_ch.data = item;
    in_ch.valid = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (req == REQ_LOAD) loads_sent++;
  endtask

  task automatic load(logic [9:0] from, logic [9:0] to, logic [31:0] wt);
    send(REQ_LOAD, from, to, wt, 10'($urandom));
  endtask

  task automatic query(logic [9:0] qn);
    send(REQ_QUERY, 10'($urandom), 10'($urandom), $urandom, qn);
  endtask

  task automatic run_paths();
    send(REQ_RUN, 10'($urandom), 10'($urandom), $urandom, 10'($urandom));
  endtask

  // drain all results, then let a trailing load finish
  task automatic settle();
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [10:0] value);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_load(int n);
    logic [9:0]  from;
    logic [9:0]  to;
    logic [31:0] wt;
    from = 10'($urandom_range(n - 1));
    to = 10'($urandom_range(n - 1));
    wt = $urandom_range(100);
    if ($urandom_range(9) == 0) from = 10'($urandom);
    if ($urandom_range(9) == 0) to = 10'($urandom);
    if ($urandom_range(5) == 0) wt = -$urandom_range(3);
    if ($urandom_range(19) == 0) wt = $urandom;
    load(from, to, wt);
  endtask

  initial begin
    int n;
    int pick;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_we = 0;
    cfg_index = CFG_NODE_COUNT;
    cfg_data = '0;
    set_idling(0);
    rst_n = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset defaults, empty graph
    query(10'd0);
    send(REQ_NONE, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 10'h3FF);
    run_paths();
    query(10'd0);
    query(10'd1023);
    settle();

    // directed: weight extremes, out-of-range edges
    write_reg(CFG_NODE_COUNT, 11'd4);
    write_reg(CFG_SOURCE_NODE, 11'd0);
    load(10'd0, 10'd1, 32'h7FFF_FFFF);
    load(10'd1, 10'd2, 32'h8000_0000);
    load(10'd2, 10'd3, 32'd5);
    load(10'd5, 10'd1, 32'd0);
    load(10'd1023, 10'd0, 32'd0);
    run_paths();
    for (int i = 0; i < 4; i++) query(10'(i));
    query(10'd1023);
    settle();

    // directed: source beyond node count
    write_reg(CFG_SOURCE_NODE, 11'd5);
    run_paths();
    query(10'd1);
    settle();

    // directed: close a negative cycle
    write_reg(CFG_SOURCE_NODE, 11'd0);
    load(10'd3, 10'd1, 32'd0);
    run_paths();
    query(10'd2);
    settle();

    // random phases over several settings and idling modes
    for (int ph = 0; ph < 24; ph++) begin
      set_idling(ph % 4);
      pick = $urandom_range(7);
      case (pick)
        0: n = 0;
        1: n = 1024;
        2: n = 2047;
        3: n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      write_reg(CFG_NODE_COUNT, 11'(n));
      n = (n == 0) ? 1 : (n > 1024 ? 1024 : n);
      if (n > 12 && $urandom_range(1)) n = 12;
      if ($urandom_range(7) == 0) write_reg(CFG_SOURCE_NODE, 11'($urandom));
      else write_reg(CFG_SOURCE_NODE, 11'($urandom_range(n - 1)));
      repeat ($urandom_range(6, 12)) random_load(n);
      run_paths();
      for (int i = 0; i < 30; i++) begin
        pick = $urandom_range(19);
        if (pick == 0)
          send(REQ_NONE, 10'($urandom), 10'($urandom), $urandom, 10'($urandom));
        else if (pick == 1) query(10'($urandom));
        else if (pick == 2 && i > 15) run_paths();
        else query(10'($urandom_range(n - 1)));
      end
      settle();
    end

    // close out on a two-node graph with both sides idling
    set_idling(3);
    write_reg(CFG_NODE_COUNT, 11'd2);
    write_reg(CFG_SOURCE_NODE, 11'd0);
    load(10'd0, 10'd1, 32'd1);
    run_paths();
    query(10'd0);
    query(10'd1);

    // drain and wait out the pipeline
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d items (%0d edge loads), %0d results checked",
             items_sent, loads_sent, results_seen);
    $display("runs that flagged a negative cycle: %0d", cycles_flagged);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
